/* sv/utf8_stream_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent check wrappers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Check that is masked while reset is asserted.
`define UTF8SD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that must also hold while reset is asserted.
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/utf8sd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Status codes, byte class masks and the result word type.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned PARTIAL_W = 15;
    localparam int unsigned PEND_W    = 2;

    // Output queue depth; two or more holds both words of a broken sequence
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    // Byte class masks and patterns
    localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
    localparam logic [7:0] ASCII_PAT  = 8'b0000_0000;
    localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] CONT_PAT   = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_PAT  = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_PAT  = 8'b1110_0000;
    localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_PAT  = 8'b1111_0000;

    // Pending continuation counts
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_STRAY    = 2'd1,
        ST_BAD_LEAD = 2'd2,
        ST_BROKEN   = 2'd3
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            last;
    } result_t;

endpackage

/* sv/utf8_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder, top level
// Decodes a UTF-8 byte stream into code points with per-word status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  byte    | in        | byte_valid/byte_stall | in_byte[7:0]
//  result  | out       | cp_valid/cp_stall     | code_point[20:0], status, last
//
//  One byte is taken per clock while byte_stall is low. A byte is registered,
//  decoded in the next cycle and its words pushed into a small output queue.
//  A broken sequence whose byte also yields its own word puts two words in
//  the queue, which the single output port sends one at a time.
//  byte_stall rises only while a byte sits in the input register and the
//  queue lacks room for its words.
//  rst_n clears the decoder state, the queue and the input register at once.
//
module utf8_stream_decoder_top #(
    parameter int unsigned FIFO_DEPTH = utf8sd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // byte channel
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [7:0]                  in_byte,
    // result channel
    output logic                        cp_valid,
    input  logic                        cp_stall,
    output logic [utf8sd_pkg::CP_W-1:0] code_point,
    output logic [1:0]                  status,
    output logic                        last
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(FIFO_DEPTH);

    // input register
    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  byte_reg;

    // decoder state
    logic [utf8sd_pkg::PEND_W-1:0]    pend_reg, pend_next;
    logic [utf8sd_pkg::PARTIAL_W-1:0] partial_reg, partial_next;

    // output queue
    utf8sd_pkg::result_t fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    tail_plus1;
    logic [CNT_W-1:0]    count_reg, count_next;

    // decode results
    utf8sd_pkg::result_t res0, res1;
    logic [1:0]          n_res;
    logic                advance;
    logic                pop;
    logic                take;

    // --------------------------------------------------------------------
    // decode of the registered byte
    // --------------------------------------------------------------------
    logic                            is_cont;
    logic                            lead_word;
    utf8sd_pkg::result_t             lead_res;
    logic [utf8sd_pkg::CP_W-1:0]     joined;

    always_comb
    begin
        is_cont   = (byte_reg & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_PAT;
        joined    = {partial_reg, byte_reg[5:0]};
        pend_next    = pend_reg;
        partial_next = partial_reg;
        lead_word = 1'b0;
        lead_res  = '{code_point: '0, status: utf8sd_pkg::ST_OK, last: 1'b1};
        res0      = '{code_point: '0, status: utf8sd_pkg::ST_OK, last: 1'b1};
        res1      = '{code_point: '0, status: utf8sd_pkg::ST_OK, last: 1'b1};
        n_res     = 2'd0;

        // byte taken as a lead: ascii, stray, opener or invalid
        if ((byte_reg & utf8sd_pkg::ASCII_MASK) == utf8sd_pkg::ASCII_PAT)
        begin
            lead_word           = 1'b1;
            lead_res.code_point = utf8sd_pkg::CP_W'(byte_reg);
        end
        else if (is_cont)
        begin
            lead_word           = 1'b1;
            lead_res.code_point = utf8sd_pkg::CP_W'(byte_reg);
            lead_res.status     = utf8sd_pkg::ST_STRAY;
        end
        else if ((byte_reg & utf8sd_pkg::LEAD2_MASK) == utf8sd_pkg::LEAD2_PAT ||
                 (byte_reg & utf8sd_pkg::LEAD3_MASK) == utf8sd_pkg::LEAD3_PAT ||
                 (byte_reg & utf8sd_pkg::LEAD4_MASK) == utf8sd_pkg::LEAD4_PAT)
        begin
            lead_word = 1'b0;
        end
        else
        begin
            lead_word       = 1'b1;
            lead_res.status = utf8sd_pkg::ST_BAD_LEAD;
        end

        if (pend_reg != utf8sd_pkg::PEND_NONE && is_cont)
        begin
            if (pend_reg == utf8sd_pkg::PEND_ONE)
            begin
                pend_next       = utf8sd_pkg::PEND_NONE;
                partial_next    = '0;
                res0.code_point = joined;
                n_res           = 2'd1;
            end
            else
            begin
                pend_next    = pend_reg - utf8sd_pkg::PEND_ONE;
                partial_next = joined[utf8sd_pkg::PARTIAL_W-1:0];
            end
        end
        else
        begin
            // a lead byte opens a new sequence, anything else closes it
            pend_next    = utf8sd_pkg::PEND_NONE;
            partial_next = '0;
            if ((byte_reg & utf8sd_pkg::LEAD2_MASK) == utf8sd_pkg::LEAD2_PAT)
            begin
                pend_next    = utf8sd_pkg::PEND_ONE;
                partial_next = utf8sd_pkg::PARTIAL_W'(byte_reg[4:0]);
            end
            else if ((byte_reg & utf8sd_pkg::LEAD3_MASK) == utf8sd_pkg::LEAD3_PAT)
            begin
                pend_next    = utf8sd_pkg::PEND_TWO;
                partial_next = utf8sd_pkg::PARTIAL_W'(byte_reg[3:0]);
            end
            else if ((byte_reg & utf8sd_pkg::LEAD4_MASK) == utf8sd_pkg::LEAD4_PAT)
            begin
                pend_next    = utf8sd_pkg::PEND_THREE;
                partial_next = utf8sd_pkg::PARTIAL_W'(byte_reg[2:0]);
            end

            if (pend_reg != utf8sd_pkg::PEND_NONE)
            begin
                // broken sequence: error word first, then the lead's own word
                res0.status = utf8sd_pkg::ST_BROKEN;
                res0.last   = ~lead_word;
                res1        = lead_res;
                n_res       = lead_word ? 2'd2 : 2'd1;
            end
            else
            begin
                res0  = lead_res;
                n_res = lead_word ? 2'd1 : 2'd0;
            end
        end
    end

    // --------------------------------------------------------------------
    // flow control
    // --------------------------------------------------------------------
    assign cp_valid = (count_reg != '0);
    assign pop      = cp_valid & ~cp_stall;

    // room after this cycle's pop must cover this byte's words
    assign advance    = byte_valid_reg &
                        (((CNT_W + 1)'(count_reg) - (CNT_W + 1)'(pop) +
                          (CNT_W + 1)'(n_res)) <= DEPTH_W);
    assign byte_stall = byte_valid_reg & ~advance;
    assign take       = byte_valid & ~byte_stall;

    assign byte_valid_next = take | (byte_valid_reg & ~advance);

    assign tail_plus1 = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg - CNT_W'(pop);
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (advance)
        begin
            count_next = count_next + CNT_W'(n_res);
            case (n_res)
                2'd1:    tail_next = tail_plus1;
                2'd2:    tail_next = (tail_plus1 == PTR_LAST) ? '0 : tail_plus1 + 1'b1;
                default: tail_next = tail_reg;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // registers
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            pend_reg       <= utf8sd_pkg::PEND_NONE;
            partial_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            if (advance)
            begin
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && n_res != 2'd0)
        begin
            fifo_reg[tail_reg] <= res0;
        end
        if (advance && n_res == 2'd2)
        begin
            fifo_reg[tail_plus1] <= res1;
        end
    end

    // queue head drives the result port directly; it holds while stalled
    utf8sd_pkg::result_t head_res;
    assign head_res   = fifo_reg[head_reg];
    assign code_point = head_res.code_point;
    assign status     = head_res.status;
    assign last       = head_res.last;

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
`include "utf8_stream_decoder_top_assert.svh"

    `UTF8SD_ASSERT_RST(a_queue_bound, clk, rst_n,
        count_reg <= CNT_W'(FIFO_DEPTH), "queue count beyond depth")
    `UTF8SD_ASSERT_RST(a_idle_partial, clk, rst_n,
        (pend_reg == utf8sd_pkg::PEND_NONE) |-> (partial_reg == '0),
        "partial value left with no open sequence")
    `UTF8SD_ASSERT_RST(a_not_last_broken, clk, rst_n,
        (cp_valid && !last) |-> (status == utf8sd_pkg::ST_BROKEN),
        "non-final word that is not a broken sequence")
    `UTF8SD_ASSERT_RST(a_stall_held, clk, rst_n,
        byte_stall |=> byte_valid_reg, "input register lost a stalled byte")

endmodule
